### rtl/core/cltc_pkg.sv
// Shared types and constants of the command line token classifier.
package cltc_pkg;

    localparam int unsigned KIND_W   = 4;
    localparam int unsigned START_W  = 8;
    localparam int unsigned LENGTH_W = 9;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W   = 2;
    localparam int unsigned QCNT_W   = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_END    = 4'd0,
        KIND_DELIM  = 4'd1,
        KIND_STR    = 4'd2,
        KIND_BROKEN = 4'd3,
        KIND_HEX    = 4'd4,
        KIND_WORD   = 4'd5,
        KIND_FLOAT  = 4'd6,
        KIND_NUM    = 4'd7,
        KIND_ERR    = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } token_t;

    // Tokens handed from the lexer to the queue in one cycle; tok1 is used
    // only when count is two.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

endpackage

### rtl/core/cltc_lexer.sv
// Front part: per-byte lexer state machine that classifies and closes tokens.
module cltc_lexer #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           char_code,
    output cltc_pkg::push_t      push
);
    import cltc_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [7:0] {
        MODE_BETWEEN = 8'b0000_0001,
        MODE_SIGN    = 8'b0000_0010,
        MODE_ZERO    = 8'b0000_0100,
        MODE_HEX     = 8'b0000_1000,
        MODE_WORD    = 8'b0001_0000,
        MODE_NUMBER  = 8'b0010_0000,
        MODE_STRING  = 8'b0100_0000,
        MODE_DISCARD = 8'b1000_0000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic             float_reg, float_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic             bsl_reg, bsl_next;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [LENGTH_W-1:0] len_of(input logic [POS_W-1:0] v);
        logic [POS_W+LENGTH_W-1:0] w;
        w = {{LENGTH_W{1'b0}}, v};
        return w[LENGTH_W-1:0];
    endfunction

    function automatic logic [START_W-1:0] start_of(input logic [POS_W-1:0] v);
        logic [POS_W+START_W-1:0] w;
        w = {{START_W{1'b0}}, v};
        return w[START_W-1:0];
    endfunction

    function automatic token_t make_tok(input kind_t k, input logic [START_W-1:0] s,
                                        input logic [LENGTH_W-1:0] l, input logic f);
        token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = f;
        return t;
    endfunction

    always_comb
    begin : lex_comb
        logic [7:0]       c;
        logic [POS_W-1:0] diff;
        mode_t            m;
        logic             done;
        logic             fin;
        logic             va;
        logic             vb;
        token_t           ta;
        token_t           tb;

        mode_next  = mode_reg;
        float_next = float_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        bsl_next   = bsl_reg;
        done = 1'b0;
        fin  = 1'b0;
        va   = 1'b0;
        vb   = 1'b0;
        ta   = make_tok(KIND_END, '0, '0, 1'b0);
        tb   = make_tok(KIND_END, '0, '0, 1'b0);
        diff = pos_reg - begin_reg;
        // Past the line limit every byte is taken as the line's end.
        c = (pos_reg >= POS_LIMIT) ? CH_NUL : char_code;
        m = mode_reg;

        if (mode_reg == MODE_DISCARD)
        begin
            if (char_code == CH_NUL)
            begin
                mode_next = MODE_BETWEEN;
                pos_next  = '0;
            end
        end
        else
        begin
            if (m == MODE_SIGN)
            begin
                done = 1'b1;
                if (is_word_start(c))
                begin
                    m = MODE_WORD;
                end
                else if (is_digit(c))
                begin
                    m = MODE_NUMBER;
                    float_next = 1'b0;
                end
                else
                begin
                    va  = 1'b1;
                    ta  = make_tok(KIND_ERR, start_of(begin_reg), LENGTH_W'(1), 1'b1);
                    fin = 1'b1;
                end
            end
            else if (m == MODE_ZERO)
            begin
                if ((c == CH_X_LO) || (c == CH_X_UP))
                begin
                    m = MODE_HEX;
                    done = 1'b1;
                end
                else
                begin
                    m = MODE_NUMBER;
                    float_next = 1'b0;
                end
            end

            if (!done)
            begin
                unique case (m)
                    MODE_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            done = 1'b1;
                        end
                        else if (c == CH_DOT)
                        begin
                            float_next = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            va = 1'b1;
                            ta = make_tok(float_next ? KIND_FLOAT : KIND_NUM,
                                          start_of(begin_reg), len_of(diff), 1'b0);
                            m  = MODE_BETWEEN;
                        end
                    end
                    MODE_HEX:
                    begin
                        if (is_xdigit(c))
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            va = 1'b1;
                            ta = make_tok(KIND_HEX, start_of(begin_reg), len_of(diff), 1'b0);
                            m  = MODE_BETWEEN;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_word_start(c) || is_digit(c))
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            va = 1'b1;
                            ta = make_tok(KIND_WORD, start_of(begin_reg), len_of(diff), 1'b0);
                            m  = MODE_BETWEEN;
                        end
                    end
                    MODE_STRING:
                    begin
                        done = 1'b1;
                        if (c == CH_NUL)
                        begin
                            va  = 1'b1;
                            ta  = make_tok(KIND_BROKEN, start_of(begin_reg),
                                           len_of(diff), 1'b1);
                            fin = 1'b1;
                        end
                        else if ((c == CH_QUOTE) && !bsl_reg)
                        begin
                            va = 1'b1;
                            ta = make_tok(KIND_STR, start_of(begin_reg),
                                          len_of(POS_W'(diff + 1'b1)), 1'b0);
                            m  = MODE_BETWEEN;
                        end
                        else
                        begin
                            bsl_next = (c == CH_BSL);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // The byte that closed a token may start the next one.
            if (!done)
            begin
                if (c == CH_NUL)
                begin
                    vb  = 1'b1;
                    tb  = make_tok(KIND_END, start_of(pos_reg), '0, 1'b1);
                    fin = 1'b1;
                end
                else if (is_space(c))
                begin
                end
                else if (c == CH_SEMI)
                begin
                    vb = 1'b1;
                    tb = make_tok(KIND_DELIM, start_of(pos_reg), LENGTH_W'(1), 1'b0);
                end
                else
                begin
                    begin_next = pos_reg;
                    if (c == CH_QUOTE)
                    begin
                        m = MODE_STRING;
                        bsl_next = 1'b0;
                    end
                    else if (c == CH_ZERO)
                    begin
                        m = MODE_ZERO;
                    end
                    else if ((c == CH_PLUS) || (c == CH_MINUS))
                    begin
                        m = MODE_SIGN;
                    end
                    else if (is_word_start(c))
                    begin
                        m = MODE_WORD;
                    end
                    else if (is_digit(c))
                    begin
                        m = MODE_NUMBER;
                        float_next = 1'b0;
                    end
                    else
                    begin
                        vb  = 1'b1;
                        tb  = make_tok(KIND_ERR, start_of(pos_reg), '0, 1'b1);
                        fin = 1'b1;
                    end
                end
            end

            if (fin)
            begin
                if (char_code == CH_NUL)
                begin
                    mode_next = MODE_BETWEEN;
                    pos_next  = '0;
                end
                else
                begin
                    mode_next = MODE_DISCARD;
                end
            end
            else
            begin
                mode_next = m;
                pos_next  = pos_reg + 1'b1;
            end
        end

        push.count = in_valid ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
        push.tok0  = va ? ta : tb;
        push.tok1  = tb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            float_reg <= 1'b0;
            pos_reg   <= '0;
            begin_reg <= '0;
            bsl_reg   <= 1'b0;
        end
        else if (in_valid)
        begin
            mode_reg  <= mode_next;
            float_reg <= float_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            bsl_reg   <= bsl_next;
        end
    end

endmodule

### rtl/core/cltc_queue.sv
// Back part: token queue that takes up to two words a cycle and delivers one while head_ready is high.
module cltc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cltc_pkg::push_t  push,
    output logic             room,
    output logic             head_valid,
    input  logic             head_ready,
    output cltc_pkg::token_t head
);
    import cltc_pkg::*;

    token_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    // Space for the two words a single byte can produce.
    assign room       = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/command_line_token_classifier_unit.sv
// Top level of the command line token classifier: lexer front, token queue back.
// The block lexes a command line at one byte per clock: a byte is taken whenever
// the four-word token queue has two free slots, and the lexer settles its state in
// the same cycle. Tokens leave one word per clock from the queue head while
// m_tready is high, so a byte that closes a token and is also a delimiter, an
// error or the line's end yields two words; bursts of such bytes, or a stalled
// output, throttle input through the queue's free space. Lines over MAX_LINE
// bytes are cut there and the rest up to the terminating zero byte is dropped.
module command_line_token_classifier_unit #(
    parameter int unsigned MAX_LINE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] token_kind, [11:4] token_start,
                                   // [20:12] token_length, [23:21] zero
    output logic        m_tlast    // last_of_line
);
    import cltc_pkg::*;

    push_t  push;
    token_t head;
    logic   room;

    assign s_tready = room;

    cltc_lexer #(
        .MAX_LINE (MAX_LINE)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && s_tready),
        .char_code (s_tdata),
        .push      (push)
    );

    cltc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {3'b000, head.length, head.start, head.kind};
    assign m_tlast = head.last;

endmodule
